>>> hdl/rntp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix number token parser package
// Widths, character codes, register indexes, status codes and the hex digit
// decoder shared by the channel interfaces and the parser.
// ----------------------------------------------------------------------------
package rntp_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int CHAR_BITS      = 8;
    localparam int CNT_BITS       = 6;
    localparam int BASE_BITS      = 5;
    localparam int DIGIT_BITS     = 5;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 6;

    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'd32;

    localparam logic [BASE_BITS-1:0] BASE_MIN   = 5'd2;
    localparam logic [BASE_BITS-1:0] BASE_MAX   = 5'd16;
    localparam logic [BASE_BITS-1:0] BASE_RESET = 5'd10;

    localparam logic [CNT_BITS-1:0] MAXD_LIMIT = 6'd32;
    localparam logic [CNT_BITS-1:0] MAXD_RESET = 6'd10;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_NUMBER_BASE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_DIGITS  = 2'd1;

    localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 5'd16;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NON_HEX  = 3'd2,
        ST_BASE     = 3'd3,
        ST_TOO_LONG = 3'd4
    } status_t;

    // Map a character to its hex digit value, DIGIT_NONE when not a hex digit.
    function automatic logic [DIGIT_BITS-1:0] hex_value(input logic [CHAR_BITS-1:0] c);
        logic [DIGIT_BITS-1:0] d;
        d = DIGIT_NONE;
        if (c inside {[8'h30:8'h39]})
        begin
            d = DIGIT_BITS'(c - 8'h30);
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            d = DIGIT_BITS'(c - 8'h41 + 8'd10);
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            d = DIGIT_BITS'(c - 8'h61 + 8'd10);
        end
        return d;
    endfunction

endpackage

>>> hdl/rntp_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one received character per word.
// ----------------------------------------------------------------------------
interface rntp_char_if;
    import rntp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

>>> hdl/rntp_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one parsed token result per word.
// ----------------------------------------------------------------------------
interface rntp_result_if;
    import rntp_pkg::*;

    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [VALUE_BITS-1:0] number_value;
    logic [CNT_BITS-1:0]   digit_count;
    logic                  ended_by_cr;

    modport source (output valid, output status, output number_value,
                    output digit_count, output ended_by_cr, input ready);
    modport sink   (input valid, input status, input number_value,
                    input digit_count, input ended_by_cr, output ready);
endinterface

>>> hdl/rntp_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data per word.
// ----------------------------------------------------------------------------
interface rntp_cfg_if;
    import rntp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/radix_number_token_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix number token parser
// Parses a stream of ASCII characters into numbers of a configured base.
// ----------------------------------------------------------------------------
// Channels: chars takes one character per word, results gives one word per
// finished token, error character or empty CR line (status, value, digit
// count, ended by CR), cfg writes the base (index 0, clamped to 2..16) and
// the digit limit (index 1, clamped to 32). Leading spaces produce no word; a
// digit updates the running value as value*base + digit, wrapping at 32 bits.
// Path: a character word passes through the input register, then through the
// digit decode and 32x5 multiply-add into the result register.
// Throughput: one character per cycle while no result is held, set by the
// combinational multiply-add.
// Reset: base 10, digit limit 10, skipping spaces, no word held.
// Stall: a held result keeps its word; the input register still takes one
// more character, then chars drops ready until results is taken.
// Configuration is taken in every cycle and must only be written while idle.
// ----------------------------------------------------------------------------
module radix_number_token_parser (
    input  logic         clk,
    input  logic         rst_n,
    rntp_cfg_if.sink     cfg,
    rntp_char_if.sink    chars,
    rntp_result_if.source results
);
    import rntp_pkg::*;

    logic [BASE_BITS-1:0]  base_reg;
    logic [CNT_BITS-1:0]   limit_reg;

    logic                  in_valid_reg;
    logic [CHAR_BITS-1:0]  char_reg;

    logic                  in_token_reg, in_token_next;
    logic [VALUE_BITS-1:0] running_reg, running_next;
    logic [CNT_BITS-1:0]   digits_reg, digits_next;

    logic                  out_valid_reg;
    status_t               status_reg, status_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  cr_reg, cr_next;

    logic                  advance;
    logic                  emit;
    logic [DIGIT_BITS-1:0] digit;
    logic [VALUE_BITS+BASE_BITS-1:0] product;

    assign cfg.ready   = 1'b1;
    assign advance     = in_valid_reg && (!out_valid_reg || results.ready);
    assign chars.ready = !in_valid_reg || advance;

    assign digit   = hex_value(char_reg);
    assign product = running_reg * base_reg;

    always_comb
    begin
        emit          = 1'b0;
        status_next   = ST_OK;
        value_next    = '0;
        count_next    = '0;
        cr_next       = 1'b0;
        in_token_next = in_token_reg;
        running_next  = running_reg;
        digits_next   = digits_reg;
        if (char_reg == CH_SPACE || char_reg == CH_CR)
        begin
            if (in_token_reg)
            begin
                emit       = 1'b1;
                value_next = running_reg;
                count_next = digits_reg;
                cr_next    = (char_reg == CH_CR);
            end
            else if (char_reg == CH_CR)
            begin
                emit        = 1'b1;
                status_next = ST_EMPTY;
                cr_next     = 1'b1;
            end
        end
        else if (digit[DIGIT_BITS-1])
        begin
            emit        = 1'b1;
            status_next = ST_NON_HEX;
            count_next  = digits_reg;
        end
        else if (digit >= base_reg)
        begin
            emit        = 1'b1;
            status_next = ST_BASE;
            count_next  = digits_reg;
        end
        else if (digits_reg >= limit_reg)
        begin
            emit        = 1'b1;
            status_next = ST_TOO_LONG;
            count_next  = limit_reg + CNT_BITS'(1);
        end
        else
        begin
            in_token_next = 1'b1;
            running_next  = product[VALUE_BITS-1:0] + VALUE_BITS'(digit);
            digits_next   = digits_reg + CNT_BITS'(1);
        end
        if (emit)
        begin
            in_token_next = 1'b0;
            running_next  = '0;
            digits_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_RESET;
            limit_reg <= MAXD_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_NUMBER_BASE)
            begin
                if (cfg.data[BASE_BITS-1:0] < BASE_MIN)
                begin
                    base_reg <= BASE_MIN;
                end
                else if (cfg.data[BASE_BITS-1:0] > BASE_MAX)
                begin
                    base_reg <= BASE_MAX;
                end
                else
                begin
                    base_reg <= cfg.data[BASE_BITS-1:0];
                end
            end
            else if (cfg.index == CFG_MAX_DIGITS)
            begin
                limit_reg <= (cfg.data > MAXD_LIMIT) ? MAXD_LIMIT : cfg.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_token_reg  <= 1'b0;
            running_reg   <= '0;
            digits_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (chars.ready)
            begin
                in_valid_reg <= chars.valid;
            end
            if (advance)
            begin
                in_token_reg <= in_token_next;
                running_reg  <= running_next;
                digits_reg   <= digits_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            char_reg <= chars.char_in;
        end
        if (advance && emit)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            count_reg  <= count_next;
            cr_reg     <= cr_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.status       = status_reg;
    assign results.number_value = value_reg;
    assign results.digit_count  = count_reg;
    assign results.ended_by_cr  = cr_reg;

    // idle means no digits and a cleared accumulator
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_token_reg |-> (digits_reg == '0 && running_reg == '0))
        else $error("idle parser holds stale digits");

    a_token_digits: assert property (@(posedge clk) disable iff (!rst_n)
        in_token_reg |-> (digits_reg != '0 && digits_reg <= limit_reg))
        else $error("token digit count out of range");

    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status != ST_OK) |->
            (results.number_value == '0 && !(results.ended_by_cr &&
             results.status != ST_EMPTY)))
        else $error("error result carries value or CR flag");

    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit && status_next == ST_OK) |=>
            (results.valid && results.digit_count != '0))
        else $error("ok result without digits");

endmodule
